[design/rfpc_pkg.sv]
// shared types and constants for the range filter pruning check
package rfpc_pkg;

  // default sizes of the range table and of the value datapath
  localparam int unsigned MAX_RANGES_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned PRED_W = 4;

  // range count after reset
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd1;

  // request opcodes
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // predicate codes of a query
  typedef enum logic [PRED_W-1:0] {
    PRED_EQ        = 4'd0,
    PRED_NE        = 4'd1,
    PRED_LT        = 4'd2,
    PRED_LE        = 4'd3,
    PRED_GT        = 4'd4,
    PRED_GE        = 4'd5,
    PRED_BETWEEN   = 4'd6,
    PRED_ISNULL    = 4'd7,
    PRED_ISNOTNULL = 4'd8,
    PRED_OTHER     = 4'd9
  } pred_e;

  // query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_e;

endpackage

[design/range_filter_prune_check_top.sv]
// range filter pruning check: range table, scan sequencer and pruning decision
//
// Usage: a request is taken at a clock edge where start_i is high and busy_o is low.
// opcode_i selects a table write (entry_index_i, entry_low_i, entry_high_i) or a
// pruning query (predicate_i, value_i, second_value_i and their null flags).
// A write completes at the accepting edge, leaves busy_o low and gives no result,
// so writes can be issued every cycle. A query raises busy_o and walks the table
// one entry per cycle through a single compare unit fed by a registered memory
// read. The scan is followed by a wait state and the decision state, from which
// done_o and prunable_o are registered and shown for one cycle. A query with a
// null operand or a predicate that never prunes skips the walk and the wait.
// busy_o drops in the cycle that shows the result, so a new request can be taken
// there. The result cannot be stalled. The user must write the range count through
// cfg_we_i / cfg_data_i only while the block is idle; the block does not enforce
// this. Reset clears the sequencer and sets the range count to 1; the table is
// not cleared and its entries must be written before a query reads them.
module range_filter_prune_check_top #(
  parameter int unsigned MAX_RANGES = rfpc_pkg::MAX_RANGES_DEF,
  parameter int unsigned VALUE_BITS = rfpc_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              opcode_i,
  input  logic [rfpc_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [VALUE_BITS-1:0]      entry_low_i,
  input  logic signed [VALUE_BITS-1:0]      entry_high_i,
  input  logic [rfpc_pkg::PRED_W-1:0]       predicate_i,
  input  logic signed [VALUE_BITS-1:0]      value_i,
  input  logic                              value_is_null_i,
  input  logic signed [VALUE_BITS-1:0]      second_value_i,
  input  logic                              second_is_null_i,
  input  logic                              cfg_we_i,
  input  logic [rfpc_pkg::CNT_W-1:0]        cfg_data_i,
  output logic                              done_o,
  output logic                              prunable_o
);
  import rfpc_pkg::*;

  localparam int unsigned AW     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned SW     = (AW > CNT_W) ? AW : CNT_W;
  localparam int unsigned CNT_MX = (1 << CNT_W) - 1;
  localparam int unsigned NMAX   = (MAX_RANGES < CNT_MX) ? MAX_RANGES : CNT_MX;

  state_e                  state_q, state_d;
  logic [SW-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        n_w;
  logic [SW-1:0]           n_last_w;

  logic                    acc_w, wr_acc_w, q_acc_w, short_w, mem_we_w;

  logic signed [VALUE_BITS-1:0] mem_lo [MAX_RANGES];
  logic signed [VALUE_BITS-1:0] mem_hi [MAX_RANGES];
  logic signed [VALUE_BITS-1:0] rd_lo_q, rd_hi_q;
  logic                    rv_q;
  logic [SW-1:0]           ridx_q;

  logic [PRED_W-1:0]       pred_q;
  logic signed [VALUE_BITS-1:0] v_q, v2_q, mn_q, mx_q;
  logic                    nul_q;

  logic                    eq_hit_q, fa_q, fb_q, ina_q, inb_q;
  logic [SW-1:0]           a_idx_q, b_idx_q;

  logic                    lo_le_v, hi_ge_v, lo_le_v2, hi_ge_v2;
  logic                    same_gap_w, res_w;
  logic                    done_q, prunable_q;

  // request accept decode
  assign acc_w    = start_i && !busy_o;
  assign wr_acc_w = acc_w && (opcode_i == OP_WRITE);
  assign q_acc_w  = acc_w && (opcode_i == OP_QUERY);
  assign mem_we_w = wr_acc_w && (32'(entry_index_i) < MAX_RANGES);
  assign short_w  = value_is_null_i || second_is_null_i || (predicate_i > PRED_BETWEEN);

  // range count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_data_i;
    end
  end

  // number of ranges in use, clamped to 1..table depth, and at most CNT_MX
  always_comb begin
    if (cnt_q == '0) begin
      n_w = CNT_W'(1);
    end else if (cnt_q > CNT_W'(NMAX)) begin
      n_w = CNT_W'(NMAX);
    end else begin
      n_w = cnt_q;
    end
  end
  assign n_last_w = SW'(n_w - CNT_W'(1));

  // range table, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we_w) begin
      mem_lo[AW'(entry_index_i)] <= entry_low_i;
      mem_hi[AW'(entry_index_i)] <= entry_high_i;
    end
    rd_lo_q <= mem_lo[idx_q[AW-1:0]];
    rd_hi_q <= mem_hi[idx_q[AW-1:0]];
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (q_acc_w) begin
          idx_d   = '0;
          state_d = short_w ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + SW'(1);
        if (idx_q == n_last_w) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // read data valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= (state_q == ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= idx_q;
  end

  // query operand capture
  always_ff @(posedge clk_i) begin
    if (q_acc_w) begin
      pred_q <= predicate_i;
      v_q    <= value_i;
      v2_q   <= second_value_i;
      nul_q  <= value_is_null_i || second_is_null_i;
    end
  end

  // shared per-entry compare unit
  assign lo_le_v  = rd_lo_q <= v_q;
  assign hi_ge_v  = rd_hi_q >= v_q;
  assign lo_le_v2 = rd_lo_q <= v2_q;
  assign hi_ge_v2 = rd_hi_q >= v2_q;

  // scan accumulators: point hit, first entry not below each bound, min and max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_hit_q <= 1'b0;
      fa_q     <= 1'b0;
      fb_q     <= 1'b0;
      ina_q    <= 1'b0;
      inb_q    <= 1'b0;
    end else if (q_acc_w) begin
      eq_hit_q <= 1'b0;
      fa_q     <= 1'b0;
      fb_q     <= 1'b0;
      ina_q    <= 1'b0;
      inb_q    <= 1'b0;
    end else if (rv_q) begin
      if (lo_le_v && hi_ge_v) begin
        eq_hit_q <= 1'b1;
      end
      if (!fa_q && hi_ge_v) begin
        fa_q  <= 1'b1;
        ina_q <= lo_le_v;
      end
      if (!fb_q && hi_ge_v2) begin
        fb_q  <= 1'b1;
        inb_q <= lo_le_v2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      if (!fa_q && hi_ge_v) begin
        a_idx_q <= ridx_q;
      end
      if (!fb_q && hi_ge_v2) begin
        b_idx_q <= ridx_q;
      end
      if (ridx_q == '0) begin
        mn_q <= rd_lo_q;
      end
      if (ridx_q == n_last_w) begin
        mx_q <= rd_hi_q;
      end
    end
  end

  // pruning decision
  assign same_gap_w = (!fa_q && !fb_q) || (fa_q && fb_q && (a_idx_q == b_idx_q));

  always_comb begin
    case (pred_e'(pred_q))
      PRED_EQ:      res_w = !eq_hit_q;
      PRED_NE:      res_w = (n_w == CNT_W'(1)) && (mn_q == v_q) && (mx_q == v_q);
      PRED_LT:      res_w = v_q <= mn_q;
      PRED_LE:      res_w = v_q < mn_q;
      PRED_GT:      res_w = v_q >= mx_q;
      PRED_GE:      res_w = v_q > mx_q;
      PRED_BETWEEN: res_w = (v2_q < v_q) || (v2_q < mn_q) || (v_q > mx_q) ||
                            (!ina_q && !inb_q && same_gap_w);
      default:      res_w = 1'b0;
    endcase
    if (nul_q) begin
      res_w = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      prunable_q <= res_w;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign prunable_o = prunable_q;

  // a result strobe follows the decision state
  a_done_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_DONE))
    else $error("result strobe without a decision cycle");

  // a table write never occupies the sequencer
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_WRITE)) |=> !busy_o)
    else $error("table write made the block busy");

  // the scan never reads past the entries in use
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= n_last_w))
    else $error("scan index beyond the ranges in use");

  // read data is only marked valid right after a scan cycle
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> ((state_q == ST_SCAN) || (state_q == ST_WAIT)))
    else $error("read data valid outside the scan");

endmodule

[bench/tb.sv]
// self-checking testbench for the range filter pruning check
`timescale 1ns / 1ps

module tb;
  import rfpc_pkg::*;

  localparam int VW = VALUE_BITS_DEF;
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  // highest code of the predicate field, beyond the named ones
  localparam logic [PRED_W-1:0] PRED_CODE_TOP = 4'd15;
  // quiet cycles before a range count write, longer than the slowest query
  localparam int SETTLE_CYC = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int TAIL_CYC = 25;

  typedef enum {K_REQ, K_CFG, K_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e        kind;
    int unsigned       gap_pct;
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic [PRED_W-1:0] pred;
    logic signed [VW-1:0] v;
    logic              v_null;
    logic signed [VW-1:0] v2;
    logic              v2_null;
    logic [CNT_W-1:0]  cnt;
  } step_t;

  typedef struct {
    logic        prunable;
    int unsigned stamp;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic opcode_i = 1'b0;
  logic [IDX_W-1:0] entry_index_i = '0;
  logic signed [VW-1:0] entry_low_i = '0;
  logic signed [VW-1:0] entry_high_i = '0;
  logic [PRED_W-1:0] predicate_i = '0;
  logic signed [VW-1:0] value_i = '0;
  logic value_is_null_i = 1'b0;
  logic signed [VW-1:0] second_value_i = '0;
  logic second_is_null_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic busy_o;
  logic done_o;
  logic prunable_o;

  range_filter_prune_check_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .entry_low_i     (entry_low_i),
    .entry_high_i    (entry_high_i),
    .predicate_i     (predicate_i),
    .value_i         (value_i),
    .value_is_null_i (value_is_null_i),
    .second_value_i  (second_value_i),
    .second_is_null_i(second_is_null_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .prunable_o      (prunable_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending requests and expected answers
  step_t    req_q[$];
  verdict_t verdict_q[$];

  // predictor state: range table and range count
  logic signed [VW-1:0] tbl_lo[MAX_RANGES_DEF];
  logic signed [VW-1:0] tbl_hi[MAX_RANGES_DEF];
  logic [CNT_W-1:0]     tbl_cnt = CNT_RESET;

  // table as planned by the stimulus, used to pick boundary values
  logic signed [VW-1:0] plan_lo[MAX_RANGES_DEF];
  logic signed [VW-1:0] plan_hi[MAX_RANGES_DEF];
  int n_planned = 0;

  int unsigned cyc = 0;
  int n_err = 0;
  int n_q_acc = 0;
  int n_done_seen = 0;
  int n_writes = 0;
  int n_cfg = 0;
  int n_checked = 0;
  int n_prunable = 0;

  // first in-use entry whose high is at or above v, n if none
  function automatic int first_at_or_above(input logic signed [VW-1:0] v, input int n);
    int i;
    for (i = 0; i < n; i++)
      if (tbl_hi[i] >= v) return i;
    return n;
  endfunction

  function automatic logic holds_value(input logic signed [VW-1:0] v, input int i, input int n);
    return i < n && tbl_lo[i] <= v && v <= tbl_hi[i];
  endfunction

  // expected pruning answer of one query
  function automatic logic predict_prune(input step_t r);
    int n;
    int i;
    int a;
    int b;
    logic signed [VW-1:0] mn;
    logic signed [VW-1:0] mx;
    logic hit;
    n = int'(tbl_cnt);
    if (n == 0) n = 1;
    if (n > MAX_RANGES_DEF) n = MAX_RANGES_DEF;
    mn = tbl_lo[0];
    mx = tbl_hi[n-1];
    if (r.v_null || r.v2_null) return 1'b0;
    case (r.pred)
      PRED_EQ: begin
        hit = 1'b0;
        for (i = 0; i < n; i++)
          if (r.v >= tbl_lo[i] && r.v <= tbl_hi[i]) hit = 1'b1;
        return !hit;
      end
      PRED_NE: return n == 1 && tbl_lo[0] == r.v && tbl_hi[0] == r.v;
      PRED_LT: return r.v <= mn;
      PRED_LE: return r.v < mn;
      PRED_GT: return r.v >= mx;
      PRED_GE: return r.v > mx;
      PRED_BETWEEN: begin
        if (r.v2 < r.v || r.v2 < mn || r.v > mx) return 1'b1;
        a = first_at_or_above(r.v, n);
        b = first_at_or_above(r.v2, n);
        return !holds_value(r.v, a, n) && !holds_value(r.v2, b, n) && a == b;
      end
      default: return 1'b0;
    endcase
  endfunction

  // update the table or queue the expected answer of an accepted request
  task automatic apply_request(input step_t r);
    verdict_t e;
    if (r.op == OP_WRITE) begin
      tbl_lo[r.idx] = r.lo;
      tbl_hi[r.idx] = r.hi;
      n_writes++;
    end else begin
      e.prunable = predict_prune(r);
      e.stamp = cyc;
      verdict_q.push_back(e);
      n_q_acc++;
    end
  endtask

  // driver: presents requests, holds off for drains and range count writes
  step_t cur_req;
  step_t blk_item;
  step_t nxt;
  bit    blk_active = 1'b0;
  int    quiet_cnt = 0;
  logic  go;
  logic  we;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      go = start_i;
      we = 1'b0;
      if (start_i && !busy_o) begin
        apply_request(cur_req);
        go = 1'b0;
      end
      if (!go) begin
        if (blk_active) begin
          if (n_q_acc != n_done_seen) quiet_cnt = 0;
          else quiet_cnt++;
          if (blk_item.kind == K_DRAIN && quiet_cnt > 0) begin
            blk_active = 1'b0;
          end else if (blk_item.kind == K_CFG && quiet_cnt >= SETTLE_CYC) begin
            we = 1'b1;
            cfg_data_i <= blk_item.cnt;
            tbl_cnt = blk_item.cnt;
            n_cfg++;
            blk_active = 1'b0;
          end
        end else if (req_q.size() != 0 && $urandom_range(0, 99) >= req_q[0].gap_pct) begin
          nxt = req_q.pop_front();
          if (nxt.kind == K_REQ) begin
            cur_req = nxt;
            go = 1'b1;
            opcode_i <= nxt.op;
            entry_index_i <= nxt.idx;
            entry_low_i <= nxt.lo;
            entry_high_i <= nxt.hi;
            predicate_i <= nxt.pred;
            value_i <= nxt.v;
            value_is_null_i <= nxt.v_null;
            second_value_i <= nxt.v2;
            second_is_null_i <= nxt.v2_null;
          end else begin
            blk_item = nxt;
            blk_active = 1'b1;
            quiet_cnt = 0;
          end
        end
      end
      start_i <= go;
      cfg_we_i <= we;
    end
  end

  // monitor: compares each answer with the oldest expectation
  verdict_t got;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_done_seen <= n_done_seen + 1;
      // an expectation stamped at this edge belongs to a request taken right now
      if (verdict_q.size() == 0 || verdict_q[0].stamp >= cyc) begin
        $error("prunable: expected no result, got %0b", prunable_o);
        n_err++;
      end else begin
        got = verdict_q.pop_front();
        n_checked <= n_checked + 1;
        if (got.prunable) n_prunable <= n_prunable + 1;
        if (prunable_o !== got.prunable) begin
          $error("prunable: expected %0b, got %0b", got.prunable, prunable_o);
          n_err++;
        end
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cyc);
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus helpers
  function automatic step_t base_step(input step_kind_e k);
    step_t s;
    s.kind = k;
    s.gap_pct = (n_planned < 300) ? 36 : (n_planned < 590) ? 70 : 0;
    s.op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_QUERY;
    s.idx = IDX_W'($urandom);
    s.lo = $urandom;
    s.hi = $urandom;
    s.pred = PRED_W'($urandom);
    s.v = $urandom;
    s.v_null = 1'($urandom);
    s.v2 = $urandom;
    s.v2_null = 1'($urandom);
    s.cnt = CNT_W'($urandom);
    return s;
  endfunction

  function automatic void push_write(input int idx, input logic signed [VW-1:0] lo,
                                     input logic signed [VW-1:0] hi);
    step_t s;
    s = base_step(K_REQ);
    s.op = OP_WRITE;
    s.idx = IDX_W'(idx);
    s.lo = lo;
    s.hi = hi;
    plan_lo[idx] = lo;
    plan_hi[idx] = hi;
    req_q.push_back(s);
    n_planned++;
  endfunction

  function automatic void push_query(input logic [PRED_W-1:0] pred,
                                     input logic signed [VW-1:0] v,
                                     input logic signed [VW-1:0] v2,
                                     input logic v_null, input logic v2_null);
    step_t s;
    s = base_step(K_REQ);
    s.op = OP_QUERY;
    s.pred = pred;
    s.v = v;
    s.v2 = v2;
    s.v_null = v_null;
    s.v2_null = v2_null;
    req_q.push_back(s);
    n_planned++;
  endfunction

  function automatic void push_cfg(input logic [CNT_W-1:0] cnt);
    step_t s;
    s = base_step(K_CFG);
    s.cnt = cnt;
    req_q.push_back(s);
  endfunction

  // extremes, random words, or a table boundary give or take one
  function automatic logic signed [VW-1:0] pick_value(input int n);
    int i;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: return VMIN;
      1: return VMAX;
      2, 3: return $urandom;
      4, 5, 6: return plan_lo[i] + VW'($urandom_range(0, 2)) - VW'(1);
      default: return plan_hi[i] + VW'($urandom_range(0, 2)) - VW'(1);
    endcase
  endfunction

  // stimulus plan and end of run
  initial begin
    int k;
    int i;
    int nq;
    int n_use;
    longint cur;
    longint lo;
    longint hi;
    longint step;
    bit wide;
    bit ends;
    bit first;
    logic [CNT_W-1:0] cnt;
    logic [PRED_W-1:0] pr;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] t;

    // single point range at the reset count
    push_write(0, 7, 7);
    push_query(PRED_NE, 7, 0, 1'b0, 1'b0);
    push_query(PRED_NE, 8, 0, 1'b0, 1'b0);
    // four ranges reaching both ends of the value space
    push_write(0, VMIN, -1000);
    push_write(1, 0, 10);
    push_write(2, 100, 1000);
    push_write(3, 5000, VMAX);
    push_cfg(CNT_W'(4));
    push_query(PRED_EQ, 5, 0, 1'b0, 1'b0);
    push_query(PRED_EQ, 50, 0, 1'b0, 1'b0);
    push_query(PRED_LT, VMIN, 0, 1'b0, 1'b0);
    push_query(PRED_LE, VMIN, 0, 1'b0, 1'b0);
    push_query(PRED_GT, VMAX, 0, 1'b0, 1'b0);
    push_query(PRED_GE, VMAX, 0, 1'b0, 1'b0);
    // between inside one gap, across a range, and with reversed bounds
    push_query(PRED_BETWEEN, 20, 50, 1'b0, 1'b0);
    push_query(PRED_BETWEEN, -5, 20, 1'b0, 1'b0);
    push_query(PRED_BETWEEN, 50, 20, 1'b0, 1'b0);
    // null tests, unknown codes and null operands never prune
    push_query(PRED_ISNULL, 50, 0, 1'b0, 1'b0);
    push_query(PRED_ISNOTNULL, 50, 0, 1'b0, 1'b0);
    push_query(PRED_OTHER, 50, 0, 1'b0, 1'b0);
    push_query(PRED_CODE_TOP, 50, 0, 1'b0, 1'b0);
    push_query(PRED_EQ, 50, 0, 1'b1, 1'b0);
    push_query(PRED_EQ, 50, 0, 1'b0, 1'b1);
    // count zero counts as one range
    push_cfg(CNT_W'(0));
    push_query(PRED_GT, -1000, 0, 1'b0, 1'b0);

    // random table sets, each followed by a burst of queries
    first = 1'b1;
    while (n_planned < 875) begin
      if (first) k = MAX_RANGES_DEF;
      else if ($urandom_range(0, 3) == 0) k = MAX_RANGES_DEF;
      else if ($urandom_range(0, 2) == 0) k = $urandom_range(1, 3);
      else k = $urandom_range(1, MAX_RANGES_DEF);
      wide = ($urandom_range(0, 9) < 3);
      ends = ($urandom_range(0, 9) < 3);
      step = 64'd4294967295 / (2 * k + 2);
      cur = wide ? (longint'(VMIN) + $urandom_range(0, 32'(step)))
                 : (longint'(-40) + $urandom_range(0, 40));
      // sorted, non-overlapping ranges; zero extra gap makes them adjacent
      for (i = 0; i < k; i++) begin
        lo = cur;
        hi = lo + (wide ? $urandom_range(0, 32'(step)) : $urandom_range(0, 3));
        cur = hi + 1 + (wide ? $urandom_range(0, 32'(step)) : $urandom_range(0, 3));
        if (lo > longint'(VMAX)) lo = VMAX;
        if (hi > longint'(VMAX)) hi = VMAX;
        if (wide && ends && i == 0) lo = VMIN;
        if (wide && ends && i == k - 1) hi = VMAX;
        push_write(i, VW'(lo), VW'(hi));
      end
      // now and then one entry breaks the ordering
      if ($urandom_range(0, 99) < 15)
        push_write($urandom_range(0, k - 1), $urandom, $urandom);
      if (first) cnt = CNT_W'(31);
      else if (k == MAX_RANGES_DEF && $urandom_range(0, 1) == 0)
        cnt = CNT_W'($urandom_range(16, 31));
      else if (k == 1 && $urandom_range(0, 1) == 0) cnt = '0;
      else cnt = CNT_W'(k);
      push_cfg(cnt);
      n_use = k;
      nq = $urandom_range(8, 30);
      for (i = 0; i < nq; i++) begin
        if ($urandom_range(0, 99) < 4)
          push_write($urandom_range(0, MAX_RANGES_DEF - 1), pick_value(n_use), pick_value(n_use));
        if ($urandom_range(0, 99) < 85) pr = PRED_W'($urandom_range(0, 6));
        else pr = PRED_W'($urandom_range(7, 15));
        a = pick_value(n_use);
        b = pick_value(n_use);
        if (pr == PRED_BETWEEN && b < a && $urandom_range(0, 9) < 6) begin
          t = a;
          a = b;
          b = t;
        end
        push_query(pr, a, b, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end
      // now and then let the block drain before the next set
      if (first || $urandom_range(0, 4) == 0) req_q.push_back(base_step(K_DRAIN));
      first = 1'b0;
    end

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until every request is taken and answered
    do @(negedge clk_i);
    while (req_q.size() != 0 || blk_active || start_i || n_q_acc != n_done_seen);
    repeat (TAIL_CYC) @(posedge clk_i);

    if (verdict_q.size() != 0) begin
      $error("prunable: %0d expected results never came", verdict_q.size());
      n_err++;
    end
    $display("Ran %0d table writes, %0d queries and %0d range count writes in %0d cycles",
             n_writes, n_q_acc, n_cfg, cyc);
    $display("Checked %0d answers, %0d of them prunable", n_checked, n_prunable);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
design/rfpc_pkg.sv
design/range_filter_prune_check_top.sv
bench/tb.sv
